@@ hdl/mtslot_pkg.sv @@
package mtslot_pkg;

	// Slot table size and the field widths that follow from it.
	localparam int SLOTS   = 16;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;
	localparam int MS_W    = 42;

	// Event types.
	localparam logic [15:0] TYPE_SYN = 16'h0000;
	localparam logic [15:0] TYPE_KEY = 16'h0001;
	localparam logic [15:0] TYPE_ABS = 16'h0003;

	// Event codes.
	localparam logic [15:0] CODE_REPORT = 16'h0000;
	localparam logic [15:0] CODE_BUTTON = 16'h0110;
	localparam logic [15:0] CODE_SLOT   = 16'h002f;
	localparam logic [15:0] CODE_POS_X  = 16'h0035;
	localparam logic [15:0] CODE_POS_Y  = 16'h0036;
	localparam logic [15:0] CODE_TRACK  = 16'h0039;
	localparam logic [15:0] CODE_PRESS  = 16'h003a;

	// Millisecond conversion: floor(usec / 1000) is (usec * USEC_RECIP) >> USEC_SHIFT,
	// exact for every 20-bit microsecond value.
	localparam logic [9:0]  MS_PER_SEC = 10'd1000;
	localparam logic [20:0] USEC_RECIP = 21'd1073742;
	localparam int          USEC_SHIFT = 30;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic apply;
		logic mul;
		logic sum;
		logic load;
	} mtslot_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_report;
		logic last_idx;
		logic out_free;
	} mtslot_status_t;

endpackage

@@ hdl/mtslot_if.sv @@
// Input event channel.
interface mtslot_ev_if;
	logic               valid;
	logic               ready;
	logic        [15:0] ev_type;
	logic        [15:0] ev_code;
	logic signed [31:0] ev_value;
	logic        [31:0] time_sec;
	logic        [19:0] time_usec;
	logic        [41:0] host_millis;

	modport source (output valid, ev_type, ev_code, ev_value, time_sec, time_usec,
		host_millis, input ready);
	modport sink (input valid, ev_type, ev_code, ev_value, time_sec, time_usec,
		host_millis, output ready);
endinterface

// Frame record channel.
interface mtslot_frame_if;
	logic               valid;
	logic               ready;
	logic        [3:0]  slot_index;
	logic               touching;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pressure;
	logic        [4:0]  finger_total;
	logic               button_down;
	logic        [41:0] time_ms;
	logic               last_slot;

	modport source (output valid, slot_index, touching, pos_x, pos_y, pressure,
		finger_total, button_down, time_ms, last_slot, input ready);
	modport sink (input valid, slot_index, touching, pos_x, pos_y, pressure,
		finger_total, button_down, time_ms, last_slot, output ready);
endinterface

@@ hdl/mtslot_ctrl.sv @@
module mtslot_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  mtslot_pkg::mtslot_status_t status,
	output mtslot_pkg::mtslot_cmd_t    cmd
);
	import mtslot_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_MUL    = 5'b00100,
		S_SUM    = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		in_ready    = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.apply = 1'b1;
				state_d   = status.is_report ? S_MUL : S_IDLE;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_SUM;
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				// One record per cycle whenever the output register can take it.
				if (status.out_free) begin
					cmd.load = 1'b1;
					if (status.last_idx) begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hdl/mtslot_dp.sv @@
module mtslot_dp (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata,
	input  mtslot_pkg::mtslot_cmd_t    cmd,
	output mtslot_pkg::mtslot_status_t status,
	mtslot_ev_if.sink                ev,
	mtslot_frame_if.source           frame
);
	import mtslot_pkg::*;

	// Captured event.
	logic        [15:0]    type_q;
	logic        [15:0]    code_q;
	logic signed [31:0]    value_q;
	logic        [31:0]    sec_q;
	logic        [19:0]    usec_q;
	logic        [MS_W-1:0] host_q;

	// Tracker state.
	logic                  use_event_time_q;
	logic                  slot_ok_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  touch_q [SLOTS];
	logic signed [31:0]    x_q     [SLOTS];
	logic signed [31:0]    y_q     [SLOTS];
	logic signed [31:0]    press_q [SLOTS];
	logic [COUNT_W-1:0]    count_q;
	logic                  button_q;

	// Timestamp path.
	logic [MS_W-1:0]       sec_ms_s1;
	logic [40:0]           usec_prod_s1;
	logic [MS_W-1:0]       time_ms_q;

	// Emit sequencing and output register.
	logic [SLOT_W-1:0]     idx_q;
	logic                  out_valid_q;

	// Capture the beat on acceptance.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			type_q  <= ev.ev_type;
			code_q  <= ev.ev_code;
			value_q <= ev.ev_value;
			sec_q   <= ev.time_sec;
			usec_q  <= ev.time_usec;
			host_q  <= ev.host_millis;
		end
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_event_time_q <= 1'b1;
		end else if (cfg_we) begin
			use_event_time_q <= cfg_wdata;
		end
	end

	// Apply a captured event to the slot table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_ok_q <= 1'b1;
			slot_q    <= '0;
			count_q   <= '0;
			button_q  <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				touch_q[i] <= 1'b0;
				x_q[i]     <= '1;
				y_q[i]     <= '1;
				press_q[i] <= '1;
			end
		end else if (cmd.apply) begin
			case (type_q)
				TYPE_KEY: begin
					if (code_q == CODE_BUTTON) begin
						button_q <= |value_q;
					end
				end
				TYPE_ABS: begin
					if (code_q == CODE_SLOT) begin
						// A negative slot is huge when read unsigned, so one compare covers both.
						slot_ok_q <= $unsigned(value_q) < 32'(SLOTS);
						slot_q    <= value_q[SLOT_W-1:0];
					end else if (slot_ok_q) begin
						if (code_q == CODE_TRACK) begin
							if (value_q[31]) begin
								touch_q[slot_q] <= 1'b0;
								x_q[slot_q]     <= '1;
								y_q[slot_q]     <= '1;
								press_q[slot_q] <= '1;
								if (count_q != '0) begin
									count_q <= count_q - COUNT_W'(1);
								end
							end else begin
								touch_q[slot_q] <= 1'b1;
								if (count_q < COUNT_W'(SLOTS)) begin
									count_q <= count_q + COUNT_W'(1);
								end
							end
						end else if (code_q == CODE_POS_X) begin
							x_q[slot_q] <= value_q;
						end else if (code_q == CODE_POS_Y) begin
							y_q[slot_q] <= value_q;
						end else if (code_q == CODE_PRESS) begin
							press_q[slot_q] <= value_q;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Millisecond stamp: products first, then the sum.
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			sec_ms_s1    <= MS_W'(sec_q) * MS_W'(MS_PER_SEC);
			usec_prod_s1 <= 41'(usec_q) * 41'(USEC_RECIP);
		end
		if (cmd.sum) begin
			time_ms_q <= use_event_time_q
				? sec_ms_s1 + MS_W'(usec_prod_s1[40:USEC_SHIFT])
				: host_q;
		end
	end

	// Slot counter for the records of one frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.sum) begin
			idx_q <= '0;
		end else if (cmd.load) begin
			idx_q <= idx_q + SLOT_W'(1);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			frame.slot_index   <= idx_q;
			frame.touching     <= touch_q[idx_q];
			frame.pos_x        <= x_q[idx_q];
			frame.pos_y        <= y_q[idx_q];
			frame.pressure     <= press_q[idx_q];
			frame.finger_total <= count_q;
			frame.button_down  <= button_q;
			frame.time_ms      <= time_ms_q;
			frame.last_slot    <= idx_q == SLOT_W'(SLOTS - 1);
		end
	end

	assign frame.valid      = out_valid_q;
	assign status.is_report = (type_q == TYPE_SYN) && (code_q == CODE_REPORT);
	assign status.last_idx  = idx_q == SLOT_W'(SLOTS - 1);
	assign status.out_free  = !out_valid_q || frame.ready;

endmodule

@@ hdl/multitouch_slot_event_tracker.sv @@
// Multitouch slot event tracker.
// Events enter on the events channel (valid/ready); a beat is taken when both
// are high. Slot, tracking id, position, pressure and button events update the
// slot table; a sync report emits one frame record per slot on the frames
// channel, slot 0 first, with last_slot set on the record of the final slot.
// The one-bit register use_event_time is written with cfg_we/cfg_wdata; the
// user must write it only while the block is idle, which the block does not
// enforce. It selects event time or host_millis for the stamp.
// A non-report event is decoded and the input is then ready again. A report
// passes through decode, the multiply stage of the millisecond stamp and the
// sum, and then one record per cycle follows when the receiver keeps ready
// high; the single output register sets that rate. A new event is accepted
// while the last record still waits. If the receiver stalls, the record holds
// in the output register and the emit sequence pauses until it is taken.
// Reset clears the slot table to no touch and -1 positions, the finger count,
// the button state and the current slot, and sets use_event_time to 1.
module multitouch_slot_event_tracker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_wdata,
	mtslot_ev_if.sink      events,
	mtslot_frame_if.source frames
);
	import mtslot_pkg::*;

	mtslot_cmd_t    cmd;
	mtslot_status_t status;

	// Sequencer.
	mtslot_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (events.valid),
		.in_ready (events.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Slot table, stamp arithmetic and output register.
	mtslot_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.ev        (events),
		.frame     (frames)
	);

endmodule

@@ hdl/mtslot_chk.sv @@
module mtslot_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  slot_index,
	input logic [4:0]  finger_total,
	input logic        last_slot
);
	import mtslot_pkg::*;

	logic [SLOT_W-1:0] exp_idx_q;

	// Slot index expected on the next record.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= last_slot ? '0 : slot_index + SLOT_W'(1);
		end
	end

	// Records of a frame come in slot order with no gap or repeat.
	a_slot_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> slot_index == exp_idx_q)
		else $error("frame record out of slot order");

	// The final-record flag marks the last slot and nothing else.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_slot == (slot_index == SLOT_W'(SLOTS - 1)))
		else $error("last_slot does not match slot_index");

	// The finger count never passes the number of slots.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> finger_total <= COUNT_W'(SLOTS))
		else $error("finger_total beyond slot count");

	// A stalled record stays offered.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(slot_index))
		else $error("stalled record dropped or changed");

endmodule

bind multitouch_slot_event_tracker mtslot_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (frames.valid),
	.out_ready    (frames.ready),
	.slot_index   (frames.slot_index),
	.finger_total (frames.finger_total),
	.last_slot    (frames.last_slot)
);
